// File: rtl/vra_pkg.sv
`timescale 1ns / 1ps
// vra_pkg: shared types, codes and defaults of the virtual range allocator.
// Depends on nothing.
package vra_pkg;

   localparam int MAX_RANGES_DEF = 32;
   localparam int PAGE_BYTES_DEF = 4096;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_RESERVE = 2'd1;
   localparam logic [1:0] ACT_FREE    = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOSPACE  = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_INS  = 2'd1;
   localparam logic [1:0] OP_DEL  = 2'd2;

   localparam logic [7:0] PRESENT_BIT = 8'h01;

   typedef struct packed {
      logic [63:0] base;
      logic [47:0] length;
      logic [7:0]  attrs;
   } entry_type;

   typedef struct packed {
      logic fit;
      logic tail_wrap;
      logic ovl;
      logic ge;
      logic match;
   } flags_type;

   typedef struct packed {
      logic [1:0]  op;
      entry_type   ent;
      logic [47:0] rlen;
      logic [63:0] addr;
      logic [64:0] addr_end;
   } cell_ctrl_type;

endpackage

// File: rtl/vra_cell.sv
`timescale 1ns / 1ps
// vra_cell: one table slot; holds a range, compares it against the command
// and shifts with its neighbors on insert or remove. Uses vra_pkg.
module vra_cell #(
   parameter int IDX        = 0,
   parameter int MAX_RANGES = vra_pkg::MAX_RANGES_DEF,
   localparam int PW = $clog2(MAX_RANGES),
   localparam int CW = $clog2(MAX_RANGES + 1)
) (
   input  logic                   clock,
   input  vra_pkg::cell_ctrl_type ctrl,
   input  logic [PW-1:0]          pos,
   input  logic [CW-1:0]          count,
   input  logic [63:0]            gap_start,
   input  vra_pkg::entry_type     left_ent,
   input  vra_pkg::entry_type     right_ent,
   output vra_pkg::entry_type     ent,
   output logic [63:0]            end_addr,
   output vra_pkg::flags_type     flags
);
   vra_pkg::entry_type ent_ff, ent_in;
   logic [63:0]        end_ff;
   vra_pkg::flags_type flags_ff, flags_in;
   logic               valid;
   logic [64:0]        gap_sum, tail_sum;

   assign valid = CW'(IDX) < count;

   always_comb begin
      ent_in = ent_ff;
      case (ctrl.op)
         vra_pkg::OP_INS: begin
            if (PW'(IDX) == pos) ent_in = ctrl.ent;
            else if (PW'(IDX) > pos) ent_in = left_ent;
         end
         vra_pkg::OP_DEL: begin
            if (PW'(IDX) >= pos) ent_in = right_ent;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_comb begin
      gap_sum  = {1'b0, gap_start} + {17'd0, ctrl.rlen};
      tail_sum = {1'b0, end_ff} + {17'd0, ctrl.rlen};
      flags_in.fit       = valid && !gap_sum[64] && (gap_sum[63:0] <= ent_ff.base);
      flags_in.tail_wrap = tail_sum[64];
      flags_in.ovl       = valid && ((ent_ff.base <= ctrl.addr) ? (end_ff > ctrl.addr)
                                     : ({1'b0, ent_ff.base} < ctrl.addr_end));
      flags_in.ge        = valid && (ent_ff.base >= ctrl.addr);
      flags_in.match     = valid && (ent_ff.base == ctrl.addr);
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      end_ff   <= ent_ff.base + {16'd0, ent_ff.length};
      flags_ff <= flags_in;
   end

   assign ent      = ent_ff;
   assign end_addr = end_ff;
   assign flags    = flags_ff;
endmodule

// File: rtl/virtual_range_allocator.sv
`timescale 1ns / 1ps
// virtual_range_allocator: first-fit range table built as a row of cells.
// A request is taken only in idle, then runs the calc / flag / decide / apply sequence
//   over the cell row before another is taken; rsp_valid is set on entering apply;
//   a stalled response holds the next command in the decide step until it is taken.
// Reset (synchronous, active high) empties the table and clears alloc_floor;
//   slot contents are left as they are and are never read while unused.
module virtual_range_allocator #(
   parameter int MAX_RANGES = vra_pkg::MAX_RANGES_DEF,
   parameter int PAGE_BYTES = vra_pkg::PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_address,
   input  logic [47:0] req_length_bytes,
   input  logic [7:0]  req_region_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_range_base,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_alloc_floor
);
   localparam int PW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   // page size is a power of two; rounding is an add and a mask
   localparam logic [48:0] PG_MASK = 49'(PAGE_BYTES - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CALC  = 3'd1;
   localparam logic [2:0] S_FLAG  = 3'd2;
   localparam logic [2:0] S_DEC   = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  act_ff;
   logic [63:0] addr_ff;
   logic [7:0]  rflags_ff;
   logic [48:0] rlen_ff;         // rounded length, bit 48 = overflow
   logic [64:0] addr_end_ff;
   logic [63:0] floor_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]  op_ff, op_in;
   logic [PW-1:0] pos_ff, pos_in;
   vra_pkg::entry_type new_ff, new_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_base_ff, rsp_base_in;

   vra_pkg::cell_ctrl_type ctrl;
   vra_pkg::entry_type     ents  [MAX_RANGES];
   logic [63:0]            ends  [MAX_RANGES];
   logic [63:0]            starts[MAX_RANGES];
   vra_pkg::flags_type     flg   [MAX_RANGES];

   assign ctrl.op       = op_ff;
   assign ctrl.ent      = new_ff;
   assign ctrl.rlen     = rlen_ff[47:0];
   assign ctrl.addr     = addr_ff;
   assign ctrl.addr_end = addr_end_ff;

   // cell row: each slot after the first sees its left neighbor's end as its gap start; slot 0 sees the floor
   for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
      assign starts[g] = (g == 0) ? floor_ff : ends[(g == 0) ? 0 : g - 1];
      vra_cell #(.IDX(g), .MAX_RANGES(MAX_RANGES)) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .pos       (pos_ff),
         .count     (count_ff),
         .gap_start (starts[g]),
         .left_ent  (ents[(g == 0) ? 0 : g - 1]),
         .right_ent (ents[(g == MAX_RANGES - 1) ? g : g + 1]),
         .ent       (ents[g]),
         .end_addr  (ends[g]),
         .flags     (flg[g])
      );
   end

   // priority picks over the registered cell flags
   logic fit_any, ovl_any, ge_any, m_any;
   logic [PW-1:0] fit_idx, ge_idx, m_idx, last_idx;
   logic full;

   always_comb begin
      fit_any = 1'b0; ovl_any = 1'b0; ge_any = 1'b0; m_any = 1'b0;
      fit_idx = '0; ge_idx = '0; m_idx = '0;
      for (int i = MAX_RANGES - 1; i >= 0; i--) begin
         if (flg[i].fit)   begin fit_any = 1'b1; fit_idx = PW'(i); end
         if (flg[i].ge)    begin ge_any  = 1'b1; ge_idx  = PW'(i); end
         if (flg[i].match) begin m_any   = 1'b1; m_idx   = PW'(i); end
         if (flg[i].ovl)   ovl_any = 1'b1;
      end
   end

   assign last_idx = PW'(count_ff - CW'(1));
   assign full     = count_ff == CW'(MAX_RANGES);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = vra_pkg::OP_HOLD;
      pos_in        = pos_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_CALC;
         S_CALC:  state_in = S_FLAG;
         S_FLAG:  state_in = S_DEC;
         S_DEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in      = S_APPLY;
               rsp_valid_in  = 1'b1;
               rsp_status_in = vra_pkg::ST_OK;
               rsp_base_in   = '0;
               new_in.length = rlen_ff[47:0];
               new_in.attrs  = rflags_ff;
               new_in.base   = addr_ff;
               case (act_ff)
                  vra_pkg::ACT_ALLOC: begin
                     if (full) rsp_status_in = vra_pkg::ST_FULL;
                     else if (rlen_ff[48]) rsp_status_in = vra_pkg::ST_NOSPACE;
                     else if (count_ff == '0) begin
                        new_in.base = floor_ff; pos_in = '0; op_in = vra_pkg::OP_INS;
                     end else if (fit_any) begin
                        new_in.base = starts[fit_idx]; pos_in = fit_idx;
                        op_in = vra_pkg::OP_INS;
                     end else if (flg[last_idx].tail_wrap) begin
                        rsp_status_in = vra_pkg::ST_NOSPACE;
                     end else begin
                        new_in.base = ends[last_idx]; pos_in = PW'(count_ff);
                        op_in = vra_pkg::OP_INS;
                     end
                     if (op_in == vra_pkg::OP_INS) begin
                        rsp_base_in = new_in.base;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  vra_pkg::ACT_RESERVE: begin
                     new_in.attrs = rflags_ff | vra_pkg::PRESENT_BIT;
                     if (full) rsp_status_in = vra_pkg::ST_FULL;
                     else if (rlen_ff[48] || addr_end_ff[64] || ovl_any)
                        rsp_status_in = vra_pkg::ST_NOSPACE;
                     else begin
                        pos_in   = ge_any ? ge_idx : PW'(count_ff);
                        op_in    = vra_pkg::OP_INS;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  vra_pkg::ACT_FREE: begin
                     if (m_any) begin
                        pos_in = m_idx; op_in = vra_pkg::OP_DEL;
                        count_in = count_ff - CW'(1);
                     end else rsp_status_in = vra_pkg::ST_NOTFOUND;
                  end
                  default: rsp_status_in = vra_pkg::ST_OK;
               endcase
            end
         end
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         op_ff        <= vra_pkg::OP_HOLD;
         rsp_valid_ff <= 1'b0;
         floor_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) floor_ff <= csr_alloc_floor;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         act_ff    <= req_action;
         addr_ff   <= req_address;
         rflags_ff <= req_region_flags;
         rlen_ff   <= ({1'b0, req_length_bytes} + PG_MASK) & ~PG_MASK;
      end
      addr_end_ff   <= {1'b0, addr_ff} + {17'd0, rlen_ff[47:0]};
      pos_ff        <= pos_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
   end

   assign req_stall      = state_ff != S_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_range_base = rsp_base_ff;

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RANGES)) else $error("range count above table size");
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_CALC)
      else $error("accepted request did not start evaluation");
   a_apply_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY |-> rsp_valid_ff) else $error("shift without response");
   a_op_only_apply: assert property (@(posedge clock) disable iff (reset)
      op_ff != vra_pkg::OP_HOLD |-> state_ff == S_APPLY)
      else $error("table shift outside apply step");
`endif
endmodule
